// ----- hdl/lz4d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ4 block decompressor package
// Shared constants, decode phase codes, payload structs and run unit types.
// ----------------------------------------------------------------------------
package lz4d_pkg;

  localparam int WINDOW_DEPTH = 65536;
  localparam int DRAIN_BURST  = 64;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int BURST_W      = $clog2(DRAIN_BURST + 1);
  localparam int SIZE_W       = 24;
  localparam int RUN_W        = 32;
  localparam int DIST_W       = 16;

  localparam logic [3:0]       NIBBLE_MAX     = 4'hF;
  localparam logic [7:0]       BYTE_MAX       = 8'hFF;
  localparam logic [RUN_W-1:0] MIN_MATCH      = 32'd4;
  localparam logic [RUN_W-1:0] MATCH_EXT_BASE = 32'd19;

  localparam logic [2:0] PH_TOKEN  = 3'd0;
  localparam logic [2:0] PH_LITEXT = 3'd1;
  localparam logic [2:0] PH_LIT    = 3'd2;
  localparam logic [2:0] PH_OFFLO  = 3'd3;
  localparam logic [2:0] PH_OFFHI  = 3'd4;
  localparam logic [2:0] PH_MEXT   = 3'd5;
  localparam logic [2:0] PH_COPY   = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_BUSY   = 2'd1;
  localparam logic [1:0] ERR_OFFSET = 2'd2;
  localparam logic [1:0] ERR_DONE   = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
    logic       in_last;
  } lz4d_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       copy_pending;
    logic       stream_done;
    logic [1:0] error_code;
  } lz4d_out_t;

  typedef enum logic {
    RU_ADD_SAT,
    RU_DEC
  } ru_op_e;

  typedef struct packed {
    ru_op_e           op;
    logic [RUN_W-1:0] a;
    logic [7:0]       b;
  } ru_req_t;

  typedef struct packed {
    logic [RUN_W-1:0] res;
    logic             zero;
  } ru_rsp_t;

endpackage

// ----- hdl/lz4d_hist_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// History RAM
// Single write port, single registered read port byte memory.
// ----------------------------------------------------------------------------
module lz4d_hist_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hdl/lz4d_run_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run length unit
// Shared saturating add and decrement for literal and match run counts.
// ----------------------------------------------------------------------------
module lz4d_run_unit
  import lz4d_pkg::*;
(
  input  ru_req_t req_i,
  output ru_rsp_t rsp_o
);

  logic [RUN_W:0]   sum;
  logic [RUN_W-1:0] res;

  always_comb begin
    sum = {1'b0, req_i.a} + {{(RUN_W - 7){1'b0}}, req_i.b};
    case (req_i.op)
      RU_ADD_SAT: res = sum[RUN_W] ? {RUN_W{1'b1}} : sum[RUN_W-1:0];
      RU_DEC:     res = req_i.a - {{(RUN_W - 1){1'b0}}, 1'b1};
      default:    res = req_i.a;
    endcase
    rsp_o.res  = res;
    rsp_o.zero = (res == '0);
  end

endmodule

// ----- hdl/lz77_token_block_decompressor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ4 block decompressor core
// Sequenced token decoder with history RAM and shared run length unit.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, in_data_i): one transfer is either a
// compressed byte (mode 0) or a drain tick (mode 1). Output channel
// (out_valid_o/out_ready_i, out_data_o): one transfer per result; run_last
// marks the final result caused by an input transfer.
// A compressed byte is held in ST_BYTE after its transfer until the output
// register is free to load its result; in_ready_o returns high in the cycle
// after the result is loaded into the output register, so bytes are decoded one at a time.
// A drain tick emits up to DRAIN_BURST copied bytes; for each, ST_CRD issues
// the history RAM read, then ST_CWR takes the registered data, writes it back
// into the ring and loads the output register. An empty drain loads a single
// result with no byte from ST_CRD. Output size is set through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle; the block does not enforce this.
// Reset returns the decoder to expect a token with all counts cleared; the
// history RAM is not cleared, since offset checks keep reads to written
// entries. When the receiver stalls, the output register holds its result
// and the sequencer waits; a new input is taken only once the previous one
// has handed over its last result to the output register.
// ----------------------------------------------------------------------------
module lz77_token_block_decompressor_core
  import lz4d_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lz4d_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lz4d_out_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i
);

  localparam int RA_W = WIN_AW + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BYTE = 2'd1;
  localparam logic [1:0] ST_CRD  = 2'd2;
  localparam logic [1:0] ST_CWR  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [2:0]        phase_q, phase_d;
  logic [RUN_W-1:0]  lit_q, lit_d;
  logic [RUN_W-1:0]  match_q, match_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [SIZE_W-1:0] produced_q, produced_d;
  logic [SIZE_W-1:0] size_q;
  logic [WIN_AW-1:0] wp_q, wp_d;
  logic              eac_q, eac_d;
  logic [BURST_W-1:0] cnt_q, cnt_d;
  lz4d_in_t          item_q, item_d;
  logic              out_valid_q, out_valid_d;
  lz4d_out_t         out_q;

  ru_req_t           ru_req;
  ru_rsp_t           ru_rsp;

  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [WIN_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              slot_free;
  logic              out_load;
  lz4d_out_t         res;
  logic              fin;
  logic              do_emit;
  logic [7:0]        emit_val;
  logic              is_full;
  logic [SIZE_W-1:0] produced_inc;
  logic [WIN_AW-1:0] wp_inc;
  logic [RA_W-1:0]   rd_sum;
  logic [7:0]        b;
  logic              last;
  logic              bad_off;

  lz4d_run_unit u_run (
    .req_i (ru_req),
    .rsp_o (ru_rsp)
  );

  lz4d_hist_ram #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (WIN_AW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;
  assign slot_free    = !out_valid_q || out_ready_i;
  assign is_full      = (produced_q >= size_q);
  assign produced_inc = produced_q + {{(SIZE_W - 1){1'b0}}, 1'b1};
  assign wp_inc       = (wp_q == WIN_AW'(WINDOW_DEPTH - 1)) ? '0
                                                            : wp_q + {{(WIN_AW - 1){1'b0}}, 1'b1};
  assign rd_sum       = RA_W'(wp_q) + RA_W'(WINDOW_DEPTH) - RA_W'(dist_q);
  assign ram_raddr    = (rd_sum >= RA_W'(WINDOW_DEPTH)) ? WIN_AW'(rd_sum - RA_W'(WINDOW_DEPTH))
                                                        : WIN_AW'(rd_sum);
  assign b            = item_q.in_byte;
  assign last         = item_q.in_last;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    lit_d      = lit_q;
    match_d    = match_q;
    dist_d     = dist_q;
    produced_d = produced_q;
    wp_d       = wp_q;
    eac_d      = eac_q;
    cnt_d      = cnt_q;
    item_d     = item_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    res        = '0;
    fin        = 1'b0;
    do_emit    = 1'b0;
    emit_val   = b;
    bad_off    = 1'b0;
    ru_req.op  = RU_DEC;
    ru_req.a   = match_q;
    ru_req.b   = b;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          cnt_d   = '0;
          state_d = in_data_i.mode ? ST_CRD : ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (slot_free) begin
          out_load     = 1'b1;
          res.run_last = 1'b1;
          state_d      = ST_IDLE;
          case (phase_q)
            PH_DONE: res.error_code = ERR_DONE;
            PH_COPY: res.error_code = ERR_BUSY;
            PH_TOKEN: begin
              lit_d   = {{(RUN_W - 4){1'b0}}, b[7:4]};
              match_d = MIN_MATCH + {{(RUN_W - 4){1'b0}}, b[3:0]};
              if (b[7:4] == NIBBLE_MAX) begin
                phase_d = PH_LITEXT;
              end else if (b[7:4] != 4'd0) begin
                phase_d = PH_LIT;
              end else begin
                phase_d = PH_OFFLO;
              end
              if (last) begin
                phase_d = PH_DONE;
              end
            end
            PH_LITEXT: begin
              ru_req.op = RU_ADD_SAT;
              ru_req.a  = lit_q;
              lit_d     = ru_rsp.res;
              if (b != BYTE_MAX) begin
                phase_d = PH_LIT;
              end
              if (last) begin
                phase_d = PH_DONE;
              end
            end
            PH_LIT: begin
              if (is_full) begin
                phase_d = PH_DONE;
              end else begin
                ru_req.op    = RU_DEC;
                ru_req.a     = lit_q;
                lit_d        = ru_rsp.res;
                phase_d      = ru_rsp.zero ? PH_OFFLO : PH_LIT;
                if (last) begin
                  phase_d = PH_DONE;
                end
                do_emit      = 1'b1;
                emit_val     = b;
                res.out_byte = b;
                res.has_byte = 1'b1;
              end
            end
            PH_OFFLO: begin
              dist_d  = {8'd0, b};
              phase_d = last ? PH_DONE : PH_OFFHI;
            end
            PH_OFFHI: begin
              dist_d = {b, dist_q[7:0]};
              if (match_q == MATCH_EXT_BASE) begin
                phase_d = last ? PH_DONE : PH_MEXT;
              end else begin
                fin = 1'b1;
              end
            end
            PH_MEXT: begin
              ru_req.op = RU_ADD_SAT;
              ru_req.a  = match_q;
              match_d   = ru_rsp.res;
              if (b != BYTE_MAX) begin
                fin = 1'b1;
              end else if (last) begin
                phase_d = PH_DONE;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
      ST_CRD: begin
        if (phase_q == PH_COPY && !is_full) begin
          ram_re  = 1'b1;
          state_d = ST_CWR;
        end else if (slot_free) begin
          out_load     = 1'b1;
          res.run_last = 1'b1;
          if (phase_q == PH_COPY) begin
            phase_d = PH_DONE;
          end
          state_d = ST_IDLE;
        end
      end
      ST_CWR: begin
        if (slot_free) begin
          out_load     = 1'b1;
          ru_req.op    = RU_DEC;
          ru_req.a     = match_q;
          match_d      = ru_rsp.res;
          phase_d      = ru_rsp.zero ? (eac_q ? PH_DONE : PH_TOKEN) : PH_COPY;
          do_emit      = 1'b1;
          emit_val     = ram_rdata;
          res.out_byte = ram_rdata;
          res.has_byte = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      bad_off = (dist_d == '0) || (SIZE_W'(dist_d) > produced_q)
             || (32'(dist_d) > 32'(WINDOW_DEPTH));
      if (bad_off) begin
        phase_d        = PH_DONE;
        res.error_code = ERR_OFFSET;
      end else begin
        phase_d = PH_COPY;
        eac_d   = last;
      end
    end

    ram_wdata = emit_val;
    if (do_emit) begin
      ram_we     = 1'b1;
      wp_d       = wp_inc;
      produced_d = produced_inc;
      if (produced_inc >= size_q) begin
        phase_d = PH_DONE;
      end
    end

    res.copy_pending = (phase_d == PH_COPY);
    res.stream_done  = (phase_d == PH_DONE);

    if (state_q == ST_CWR && slot_free) begin
      res.run_last = !((BURST_W'(cnt_q) + {{(BURST_W - 1){1'b0}}, 1'b1}
                        < BURST_W'(DRAIN_BURST)) && (phase_d == PH_COPY));
      if (res.run_last) begin
        state_d = ST_IDLE;
      end else begin
        cnt_d   = cnt_q + {{(BURST_W - 1){1'b0}}, 1'b1};
        state_d = ST_CRD;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_TOKEN;
      lit_q       <= '0;
      match_q     <= '0;
      dist_q      <= '0;
      produced_q  <= '0;
      wp_q        <= '0;
      eac_q       <= 1'b0;
      cnt_q       <= '0;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      lit_q       <= lit_d;
      match_q     <= match_d;
      dist_q      <= dist_d;
      produced_q  <= produced_d;
      wp_q        <= wp_d;
      eac_q       <= eac_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (out_load) begin
      out_q <= res;
    end
  end

endmodule

// ----- hdl/lz4d_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ4 decompressor port checker
// Concurrent checks on the top level handshake and result fields.
// ----------------------------------------------------------------------------
module lz4d_checker
  import lz4d_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input lz4d_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready high right after input transfer");

  a_err_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != ERR_NONE |->
      !out_data_o.has_byte && out_data_o.run_last)
    else $error("error result carries a byte or is not last");

  a_pend_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.copy_pending && out_data_o.stream_done))
    else $error("copy pending and stream done together");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_byte |-> out_data_o.out_byte == 8'd0)
    else $error("empty result with nonzero byte");

endmodule

bind lz77_token_block_decompressor_core lz4d_checker u_lz4d_checker (.*);
